>>> rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, status codes and the result item type of the PPM P6 parser.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned POS_W    = 12;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY     = 3'd0,
    ST_BADMAGIC = 3'd1,
    ST_BADNUM   = 3'd2,
    ST_BADVAL   = 3'd3,
    ST_NOSEP    = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_DONE     = 3'd6
  } status_t;

  localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
  localparam logic [BYTE_W-1:0] CH_SIX  = 8'h36;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam int unsigned       MAXVAL  = 255;

  typedef struct packed {
    status_t           status;
    logic              header_ok;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic              pixel_valid;
    logic [POS_W-1:0]  pixel_x;
    logic [POS_W-1:0]  pixel_y;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } out_item_t;

endpackage

>>> rtl/pps_in_if.sv
// ----------------------------------------------------------------------------
// pps_in_if
// Byte channel into the parser: one file byte per item with framing flags.
// ----------------------------------------------------------------------------
interface pps_in_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first;
  logic              last;

  modport source (output valid, output data_byte, output first, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input first, input last,
                  output ready);
endinterface

>>> rtl/pps_out_if.sv
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel of the parser: status, header fields and completed pixels.
// ----------------------------------------------------------------------------
interface pps_out_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic [STATUS_W-1:0] status;
  logic              header_ok;
  logic [DIM_W-1:0]  width;
  logic [DIM_W-1:0]  height;
  logic              pixel_valid;
  logic [POS_W-1:0]  pixel_x;
  logic [POS_W-1:0]  pixel_y;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;

  modport source (output valid, output status, output header_ok, output width,
                  output height, output pixel_valid, output pixel_x,
                  output pixel_y, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input status, input header_ok, input width,
                  input height, input pixel_valid, input pixel_x,
                  input pixel_y, input red, input green, input blue,
                  output ready);
endinterface

>>> rtl/ppm_p6_stream_parser.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser
// Parses a binary PPM (P6) byte stream: header check, then RGB pixels with
// their column and row, one result item per input byte.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                                         Handshake
//   in_ch    in   data_byte, first, last                          valid/ready
//   out_ch   out  status, header_ok, width, height, pixel_valid,  valid/ready
//                 pixel_x, pixel_y, red, green, blue
//
// One item per clock while out_ch does not stall; the result appears in the
// cycle after the byte is taken, held in the output register.
// The parser state and the output register update together, so a byte is
// taken whenever the output register is empty or being drained.
// A stall on out_ch holds the result and back-pressures in_ch.
// rst_n (synchronous) returns the parser to the first magic byte; a byte
// marked first does the same for that byte.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser #(
  parameter int unsigned MAX_DIM = pps_pkg::MAX_DIM_DEF
) (
  input logic   clk,
  input logic   rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);
  import pps_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIM + 1);
  localparam int unsigned XW = AW + 4;

  typedef enum logic [5:0] {
    PH_MAGIC0 = 6'b000001,
    PH_MAGIC1 = 6'b000010,
    PH_NUMBER = 6'b000100,
    PH_PIXELS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_ERR    = 6'b100000
  } phase_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  phase_t            phase_r, phase_nxt, ph_c;
  status_t           err_r, err_nxt;
  logic              cmt_r, cmt_nxt, cmt_c;
  logic [AW-1:0]     acc_r, acc_nxt, acc_c;
  logic              dseen_r, dseen_nxt, dseen_c;
  logic [1:0]        fidx_r, fidx_nxt, fidx_c;
  logic [AW-1:0]     w_r, w_nxt, w_c;
  logic [AW-1:0]     h_r, h_nxt, h_c;
  logic [BYTE_W-1:0] red_r, red_nxt;
  logic [BYTE_W-1:0] grn_r, grn_nxt;
  logic [1:0]        comp_r, comp_nxt, comp_c;
  logic [AW-1:0]     col_r, col_nxt, col_c;
  logic [AW-1:0]     row_r, row_nxt, row_c;

  out_item_t         out_r, out_nxt;
  logic              out_valid_r;
  logic              in_fire;

  logic [BYTE_W-1:0] b;
  logic              is_digit;
  logic [XW-1:0]     dval;
  logic [XW-1:0]     acc_mac;
  logic [AW-1:0]     col_inc, row_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign b        = in_ch.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = XW'(b - CH_ZERO);

  always_comb begin
    // A byte marked first sees the parser as if just reset.
    ph_c    = in_ch.first ? PH_MAGIC0 : phase_r;
    cmt_c   = in_ch.first ? 1'b0 : cmt_r;
    acc_c   = in_ch.first ? '0 : acc_r;
    dseen_c = in_ch.first ? 1'b0 : dseen_r;
    fidx_c  = in_ch.first ? 2'd0 : fidx_r;
    w_c     = in_ch.first ? '0 : w_r;
    h_c     = in_ch.first ? '0 : h_r;
    comp_c  = in_ch.first ? 2'd0 : comp_r;
    col_c   = in_ch.first ? '0 : col_r;
    row_c   = in_ch.first ? '0 : row_r;

    acc_mac = (XW'(acc_c) << 3) + (XW'(acc_c) << 1) + dval;
    col_inc = col_c + AW'(1);
    row_inc = row_c + AW'(1);

    phase_nxt = ph_c;
    err_nxt   = err_r;
    cmt_nxt   = cmt_c;
    acc_nxt   = acc_c;
    dseen_nxt = dseen_c;
    fidx_nxt  = fidx_c;
    w_nxt     = w_c;
    h_nxt     = h_c;
    red_nxt   = red_r;
    grn_nxt   = grn_r;
    comp_nxt  = comp_c;
    col_nxt   = col_c;
    row_nxt   = row_c;

    out_nxt             = '0;

    case (ph_c)
      PH_MAGIC0: begin
        if (b == CH_P) begin
          phase_nxt = PH_MAGIC1;
        end else begin
          phase_nxt = PH_ERR;
          err_nxt   = ST_BADMAGIC;
        end
      end
      PH_MAGIC1: begin
        if (b == CH_SIX) begin
          phase_nxt = PH_NUMBER;
        end else begin
          phase_nxt = PH_ERR;
          err_nxt   = ST_BADMAGIC;
        end
      end
      PH_NUMBER: begin
        if (!dseen_c) begin
          if (cmt_c) begin
            if (b == CH_LF) cmt_nxt = 1'b0;
          end else if (b == CH_HASH) begin
            cmt_nxt = 1'b1;
          end else if (is_space(b)) begin
            cmt_nxt = 1'b0;
          end else if (is_digit) begin
            dseen_nxt = 1'b1;
            acc_nxt   = AW'(dval);
            if (dval > XW'(MAX_DIM)) begin
              phase_nxt = PH_ERR;
              err_nxt   = ST_BADNUM;
            end
          end else begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_BADNUM;
          end
        end else if (is_digit) begin
          acc_nxt = AW'(acc_mac);
          if (acc_mac > XW'(MAX_DIM)) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_BADNUM;
          end
        end else begin
          // Any non-digit ends the number and is consumed with it.
          dseen_nxt = 1'b0;
          cmt_nxt   = 1'b0;
          acc_nxt   = '0;
          if (fidx_c == 2'd0) begin
            w_nxt    = acc_c;
            fidx_nxt = 2'd1;
          end else if (fidx_c == 2'd1) begin
            h_nxt    = acc_c;
            fidx_nxt = 2'd2;
          end else if ((XW'(acc_c) != XW'(MAXVAL)) || (w_c == '0) || (h_c == '0)) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_BADVAL;
          end else if (!is_space(b)) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_NOSEP;
          end else begin
            phase_nxt = PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        if (comp_c == 2'd0) begin
          red_nxt  = b;
          comp_nxt = 2'd1;
        end else if (comp_c == 2'd1) begin
          grn_nxt  = b;
          comp_nxt = 2'd2;
        end else begin
          comp_nxt            = 2'd0;
          out_nxt.pixel_valid = 1'b1;
          out_nxt.pixel_x     = POS_W'(col_c);
          out_nxt.pixel_y     = POS_W'(row_c);
          out_nxt.red         = red_r;
          out_nxt.green       = grn_r;
          out_nxt.blue        = b;
          if (col_inc >= w_c) begin
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_inc >= h_c) phase_nxt = PH_DONE;
          end else begin
            col_nxt = col_inc;
          end
        end
      end
      default: begin
      end
    endcase

    if (in_ch.last && (phase_nxt != PH_DONE) && (phase_nxt != PH_ERR)) begin
      phase_nxt = PH_ERR;
      err_nxt   = ST_TRUNC;
    end

    if (phase_nxt == PH_DONE) begin
      out_nxt.status = ST_DONE;
    end else if (phase_nxt == PH_ERR) begin
      out_nxt.status = err_nxt;
    end else begin
      out_nxt.status = ST_BUSY;
    end
    out_nxt.header_ok = (phase_nxt == PH_PIXELS) || (phase_nxt == PH_DONE);
    out_nxt.width     = DIM_W'(w_nxt);
    out_nxt.height    = DIM_W'(h_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC0;
      err_r       <= ST_BUSY;
      cmt_r       <= 1'b0;
      acc_r       <= '0;
      dseen_r     <= 1'b0;
      fidx_r      <= 2'd0;
      w_r         <= '0;
      h_r         <= '0;
      comp_r      <= 2'd0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
        cmt_r   <= cmt_nxt;
        acc_r   <= acc_nxt;
        dseen_r <= dseen_nxt;
        fidx_r  <= fidx_nxt;
        w_r     <= w_nxt;
        h_r     <= h_nxt;
        comp_r  <= comp_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      red_r <= red_nxt;
      grn_r <= grn_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.header_ok   = out_r.header_ok;
  assign out_ch.width       = out_r.width;
  assign out_ch.height      = out_r.height;
  assign out_ch.pixel_valid = out_r.pixel_valid;
  assign out_ch.pixel_x     = out_r.pixel_x;
  assign out_ch.pixel_y     = out_r.pixel_y;
  assign out_ch.red         = out_r.red;
  assign out_ch.green       = out_r.green;
  assign out_ch.blue        = out_r.blue;

`ifndef NO_ASSERTIONS
  // An error holds until a byte marked first arrives.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.first && (phase_r == PH_ERR))
      |=> ((phase_r == PH_ERR) && $stable(err_r)))
    else $error("error state left without a first byte");

  // A pixel is only reported while pixel data flows or on a truncating byte.
  a_pix_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.pixel_valid)
      |-> (out_ch.header_ok || (out_ch.status == ST_TRUNC)))
    else $error("pixel reported outside pixel data");

  // An accepted header always has non-zero dimensions.
  a_hdr_dims: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.header_ok)
      |-> ((out_ch.width != '0) && (out_ch.height != '0)))
    else $error("header accepted with a zero dimension");

  // Every accepted byte yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte produced no result");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PPM P6 byte parser. Whole files are streamed in
// with random content and deliberate faults. A byte-level model of the parser
// predicts every result item, and each accepted item is checked field by
// field. Both channels idle at random, and the output is held off for a
// while so that back-pressure reaches the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  typedef enum logic [2:0] {
    AT_MAGIC_P, AT_MAGIC_6, IN_HEADER, IN_PIXELS, IMAGE_DONE, HELD_ERROR
  } parse_phase_t;

  typedef enum logic [1:0] {FLD_WIDTH, FLD_HEIGHT, FLD_MAXVAL} header_field_t;

  typedef enum int {
    F_GOOD, F_BAD_MAGIC, F_NO_DIGITS, F_TOO_BIG, F_BAD_VALUES, F_NO_SEP,
    F_TRUNCATED, F_CORRUPT, F_WIDE
  } file_kind_t;

  localparam int N_KINDS = int'(F_WIDE) + 1;

  class ppm_parse_tracker;
    parse_phase_t      phase;
    status_t           err_code;
    bit                in_comment;
    bit                digit_seen;
    header_field_t     field;
    int unsigned       acc;
    int unsigned       img_w;
    int unsigned       img_h;
    int unsigned       comp_idx;
    int unsigned       col;
    int unsigned       row;
    logic [BYTE_W-1:0] red_h;
    logic [BYTE_W-1:0] green_h;
    out_item_t         pending_results[$];
    int unsigned       n_checked;
    int unsigned       failures;

    function new();
      restart();
      n_checked = 0;
      failures  = 0;
    endfunction

    function void restart();
      phase      = AT_MAGIC_P;
      err_code   = ST_BUSY;
      in_comment = 0;
      digit_seen = 0;
      field      = FLD_WIDTH;
      acc        = 0;
      img_w      = 0;
      img_h      = 0;
      comp_idx   = 0;
      col        = 0;
      row        = 0;
      red_h      = '0;
      green_h    = '0;
    endfunction

    static function bit is_space(logic [BYTE_W-1:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void fail(status_t code);
      phase    = HELD_ERROR;
      err_code = code;
    endfunction

    // Header bytes: whitespace and comments before a number, then its digits,
    // then the single byte that ends it.
    function void header_byte(logic [BYTE_W-1:0] b);
      bit digit;
      digit = (b >= CH_ZERO && b <= CH_NINE);
      if (!digit_seen) begin
        if (in_comment) begin
          if (b == CH_LF) in_comment = 0;
        end else if (b == CH_HASH) begin
          in_comment = 1;
        end else if (digit) begin
          digit_seen = 1;
          acc = 32'(b - CH_ZERO);
          if (acc > MAX_DIM_DEF) fail(ST_BADNUM);
        end else if (!is_space(b)) begin
          fail(ST_BADNUM);
        end
        return;
      end
      if (digit) begin
        acc = acc * 10 + 32'(b - CH_ZERO);
        if (acc > MAX_DIM_DEF) fail(ST_BADNUM);
        return;
      end
      digit_seen = 0;
      in_comment = 0;
      case (field)
        FLD_WIDTH: begin
          img_w = acc;
          field = FLD_HEIGHT;
        end
        FLD_HEIGHT: begin
          img_h = acc;
          field = FLD_MAXVAL;
        end
        default: begin
          if (acc != MAXVAL || img_w == 0 || img_h == 0) fail(ST_BADVAL);
          else if (!is_space(b)) fail(ST_NOSEP);
          else phase = IN_PIXELS;
        end
      endcase
      acc = 0;
    endfunction

    function void parse_byte(logic [BYTE_W-1:0] b, logic f, logic l);
      out_item_t e;
      e = '0;
      if (f) restart();
      case (phase)
        AT_MAGIC_P: if (b == CH_P) phase = AT_MAGIC_6; else fail(ST_BADMAGIC);
        AT_MAGIC_6: if (b == CH_SIX) phase = IN_HEADER; else fail(ST_BADMAGIC);
        IN_HEADER:  header_byte(b);
        IN_PIXELS: begin
          if (comp_idx == 0) begin
            red_h    = b;
            comp_idx = 1;
          end else if (comp_idx == 1) begin
            green_h  = b;
            comp_idx = 2;
          end else begin
            comp_idx      = 0;
            e.pixel_valid = 1'b1;
            e.pixel_x     = POS_W'(col);
            e.pixel_y     = POS_W'(row);
            e.red         = red_h;
            e.green       = green_h;
            e.blue        = b;
            col++;
            if (col >= img_w) begin
              col = 0;
              row++;
              if (row >= img_h) phase = IMAGE_DONE;
            end
          end
        end
        default: ;
      endcase
      // A final byte that leaves the image unfinished means the file was cut.
      if (l && phase inside {AT_MAGIC_P, AT_MAGIC_6, IN_HEADER, IN_PIXELS})
        fail(ST_TRUNC);
      if (phase == IMAGE_DONE) e.status = ST_DONE;
      else if (phase == HELD_ERROR) e.status = err_code;
      else e.status = ST_BUSY;
      e.header_ok = (phase == IN_PIXELS || phase == IMAGE_DONE);
      e.width     = DIM_W'(img_w);
      e.height    = DIM_W'(img_h);
      pending_results.push_back(e);
    endfunction

    function string show(out_item_t t);
      return $sformatf("status=%0d hdr=%0b w=%0d h=%0d pv=%0b x=%0d y=%0d rgb=%02h/%02h/%02h",
                       t.status, t.header_ok, t.width, t.height, t.pixel_valid,
                       t.pixel_x, t.pixel_y, t.red, t.green, t.blue);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     bad;
      n_checked++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected: %s",
                               n_checked, show(got)));
        return;
      end
      want = pending_results.pop_front();
      bad  = "";
      if (got.status      !== want.status)      bad = {bad, " status"};
      if (got.header_ok   !== want.header_ok)   bad = {bad, " header_ok"};
      if (got.width       !== want.width)       bad = {bad, " width"};
      if (got.height      !== want.height)      bad = {bad, " height"};
      if (got.pixel_valid !== want.pixel_valid) bad = {bad, " pixel_valid"};
      if (got.pixel_x     !== want.pixel_x)     bad = {bad, " pixel_x"};
      if (got.pixel_y     !== want.pixel_y)     bad = {bad, " pixel_y"};
      if (got.red         !== want.red)         bad = {bad, " red"};
      if (got.green       !== want.green)       bad = {bad, " green"};
      if (got.blue        !== want.blue)        bad = {bad, " blue"};
      if (bad != "")
        note_failure($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                               n_checked, bad, show(want), show(got)));
    endfunction

    function void flush_leftovers();
      if (pending_results.size() != 0) begin
        failures += pending_results.size();
        $display("MISMATCH: %0d expected results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  pps_in_if  in_if ();
  pps_out_if out_if ();

  ppm_p6_stream_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  ppm_parse_tracker tracker = new();

  int unsigned n_sent   = 0;
  int unsigned n_seen   = 0;
  int unsigned n_files  = 0;
  int unsigned n_pixels = 0;
  int unsigned status_hits[8];
  bit          rx_hold;

  function automatic bit quiet_window(int unsigned n);
    return n >= 400 && n < 550;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_space();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SP : CH_TAB + BYTE_W'(k);
  endfunction

  // Any byte that is neither a digit nor whitespace, nor '#' unless allowed.
  function automatic logic [BYTE_W-1:0] pick_non_space(bit allow_hash);
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || ppm_parse_tracker::is_space(c) ||
           (!allow_hash && c == CH_HASH));
    return c;
  endfunction

  function automatic void append_text(ref logic [BYTE_W-1:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(BYTE_W'(s[i]));
  endfunction

  // Builds one file of the given kind; last_at is the index of the byte that
  // carries the last flag, or -1 for none.
  function automatic void build_file(input file_kind_t kind,
                                     ref logic [BYTE_W-1:0] q[$],
                                     output int last_at);
    int unsigned       vals[3];
    int unsigned       odd_maxvals[4] = '{0, 254, 256, 4096};
    int unsigned       npix;
    int unsigned       k;
    int unsigned       pos;
    int                bad_at;
    logic [BYTE_W-1:0] terms[3];
    logic [BYTE_W-1:0] c;
    q.delete();
    vals[0] = $urandom_range(1, 5);
    vals[1] = $urandom_range(1, 3);
    vals[2] = MAXVAL;
    npix    = vals[0] * vals[1];
    for (int i = 0; i < 2; i++)
      terms[i] = ($urandom_range(4) != 0) ? pick_space() : pick_non_space(1'b1);
    terms[2] = pick_space();
    bad_at   = -1;
    case (kind)
      F_NO_DIGITS:  bad_at = $urandom_range(0, 2);
      F_TOO_BIG:    vals[$urandom_range(0, 2)] = $urandom_range(MAX_DIM_DEF + 1, 99999);
      F_BAD_VALUES: begin
        k = $urandom_range(0, 2);
        vals[k] = (k == 2) ? odd_maxvals[$urandom_range(0, 3)] : 0;
      end
      F_NO_SEP:     terms[2] = pick_non_space(1'b1);
      F_WIDE: begin
        vals[$urandom_range(0, 1)] = MAX_DIM_DEF;
        npix = $urandom_range(1, 4);
      end
      default: ;
    endcase
    q.push_back(CH_P);
    q.push_back(CH_SIX);
    for (int f = 0; f < 3; f++) begin
      repeat ($urandom_range(0, 2)) q.push_back(pick_space());
      if ($urandom_range(3) == 0) begin
        q.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          do c = BYTE_W'($urandom_range(0, 255));
          while (c == CH_LF);
          q.push_back(c);
        end
        q.push_back(CH_LF);
        repeat ($urandom_range(0, 1)) q.push_back(pick_space());
      end
      if (bad_at == f) q.push_back(pick_non_space(1'b0));
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) q.push_back(CH_ZERO);
      append_text(q, $sformatf("%0d", vals[f]));
      q.push_back(terms[f]);
    end
    repeat (3 * npix) q.push_back(BYTE_W'($urandom_range(0, 255)));
    last_at = ($urandom_range(9) == 0) ? -1 : q.size() - 1;
    case (kind)
      F_BAD_MAGIC: begin
        pos = $urandom_range(0, 1);
        q[pos] = q[pos] ^ BYTE_W'($urandom_range(1, 255));
      end
      F_CORRUPT: begin
        pos = $urandom_range(0, q.size() - 1);
        q[pos] = q[pos] ^ BYTE_W'($urandom_range(1, 255));
      end
      F_TRUNCATED: last_at = $urandom_range(0, q.size() - 2);
      F_WIDE:      last_at = q.size() - 1;
      F_GOOD: begin
        // Bytes after a complete image must be ignored.
        if ($urandom_range(2) == 0) begin
          repeat ($urandom_range(1, 4)) q.push_back(BYTE_W'($urandom_range(0, 255)));
          if (last_at >= 0) last_at = q.size() - 1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l);
    while (!quiet_window(n_sent) && $urandom_range(99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.first     <= f;
    in_if.last      <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.parse_byte(b, f, l);
    n_sent++;
  endtask

  task automatic send_file(ref logic [BYTE_W-1:0] q[$], input int last_at,
                           input bit with_first);
    for (int i = 0; i < q.size(); i++)
      put_byte(q[i], with_first && i == 0, i == last_at);
    n_files++;
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !rx_hold && (quiet_window(n_seen) || $urandom_range(99) >= 16);
    end
  end

  // One long hold-off on the output while the sender keeps offering items.
  initial begin
    rx_hold <= 1'b0;
    wait (n_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_seen++;
      status_hits[out_if.status]++;
      if (out_if.pixel_valid) n_pixels++;
      tracker.check_result('{status:      status_t'(out_if.status),
                             header_ok:   out_if.header_ok,
                             width:       out_if.width,
                             height:      out_if.height,
                             pixel_valid: out_if.pixel_valid,
                             pixel_x:     out_if.pixel_x,
                             pixel_y:     out_if.pixel_y,
                             red:         out_if.red,
                             green:       out_if.green,
                             blue:        out_if.blue});
    end
  end

  initial begin : main
    logic [BYTE_W-1:0] file_q[$];
    int                last_at;
    int unsigned       directed_end;
    int unsigned       n;
    file_kind_t        kind;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.first     <= 1'b0;
    in_if.last      <= 1'b0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest valid image with extreme pixel bytes, ending on the last flag.
    append_text(file_q, "P6 1 1 255\n");
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h5A);
    send_file(file_q, file_q.size() - 1, 1'b1);
    // A wrong magic byte that is also the last byte keeps its own error.
    file_q.delete();
    append_text(file_q, "Q");
    send_file(file_q, 0, 1'b1);
    // A letter where a number should start.
    file_q.delete();
    append_text(file_q, "P6Z");
    send_file(file_q, -1, 1'b1);
    // A width that passes the limit part-way through its digits.
    file_q.delete();
    append_text(file_q, "P69999");
    send_file(file_q, -1, 1'b1);

    directed_end = n_sent;
    n = 0;
    while (n_sent < directed_end + RANDOM_ITEMS) begin
      if (n < N_KINDS) kind = file_kind_t'(n);
      else if ($urandom_range(99) < 50) kind = F_GOOD;
      else kind = file_kind_t'($urandom_range(1, N_KINDS - 1));
      build_file(kind, file_q, last_at);
      send_file(file_q, last_at, $urandom_range(19) != 0);
      if ($urandom_range(5) == 0)
        repeat ($urandom_range(1, 3))
          put_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(7) == 0,
                   1'($urandom_range(1)));
      n++;
    end
    in_if.valid <= 1'b0;

    for (int k = 0; k < 1000 && tracker.pending_results.size() != 0; k++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.flush_leftovers();

    $display("Streamed %0d bytes in %0d files; %0d results checked, %0d of them pixels.",
             n_sent, n_files, n_seen, n_pixels);
    $display("Status mix busy/magic/number/values/separator/truncated/done: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6]);
    if (tracker.failures == 0) begin
      $display("[ppm_p6_stream_parser] OK");
    end else begin
      $display("%0d failures counted.", tracker.failures);
      $display("[ppm_p6_stream_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Run did not finish in time.");
    $display("[ppm_p6_stream_parser] ERROR");
    $finish;
  end

endmodule

>>> ppm_p6_stream_parser.f
rtl/pps_pkg.sv
rtl/pps_in_if.sv
rtl/pps_out_if.sv
rtl/ppm_p6_stream_parser.sv
tb/testbench.sv
